/* hw/rtl/hlc_pkg.sv */
// Shared types, widths and codes of the page history unit.
package hlc_pkg;

  // Store size and the widths that follow from it
  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  // one spare bit so that index + 2 never wraps in a compare
  localparam int CMP_W = CNT_W + 1;

  // Request codes
  localparam logic [2:0] REQ_VISIT = 3'd0;
  localparam logic [2:0] REQ_BACK  = 3'd1;
  localparam logic [2:0] REQ_FWD   = 3'd2;
  localparam logic [2:0] REQ_SHOW  = 3'd3;
  localparam logic [2:0] REQ_CLOSE = 3'd4;
  localparam logic [2:0] REQ_HIST  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_PREV  = 3'd1;
  localparam logic [2:0] ST_NO_FWD   = 3'd2;
  localparam logic [2:0] ST_NO_TAB   = 3'd3;
  localparam logic [2:0] ST_NO_CLOSE = 3'd4;
  localparam logic [2:0] ST_NO_HIST  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] page_tag;
  } hlc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_id;
    logic [63:0] entry_tag;
    logic        last;
  } hlc_out_t;

  // One stored history entry
  typedef struct packed {
    logic [31:0] id;
    logic [63:0] tag;
  } hlc_entry_t;

  // Store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    hlc_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } hlc_mem_req_t;

endpackage

/* hw/rtl/history_list_with_cursor_unit.sv */
// Top level of the page history unit: sequencer and entry store.
//
// Browser-style page history of up to HISTORY_DEPTH entries (id, 64-bit tag)
// with a cursor, taking one request word at a time and returning result words
// through an output register. Visit, back, forward, show and errors pass
// through the emit state, which hands the result word to the output register
// once it is free; close hands over its word likewise, then moves each entry
// above the cursor down one per cycle through the store's write and read
// ports; history gives one word per cycle for each entry while the output is
// drained, paced by the store's registered read port. A new request is taken
// once the previous one is finished, even while its last word still waits in
// the output register.
// The store needs no clearing after reset: only written entries are read.
module history_list_with_cursor_unit import hlc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hlc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hlc_out_t out_data
);

  hlc_mem_req_t mem_req;
  hlc_entry_t   rd_data;

  // control
  hlc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  // entry memory
  hlc_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

/* hw/rtl/hlc_store.sv */
// Entry store: one write port, one read port with registered read data.
module hlc_store import hlc_pkg::*; (
  input  logic         clk,
  input  hlc_mem_req_t mem_req,
  output hlc_entry_t   rd_data
);

  hlc_entry_t mem [HISTORY_DEPTH];
  hlc_entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/hlc_seq.sv */
// Sequencer: request decode, cursor and count, close shift loop, history walk.
module hlc_seq import hlc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  hlc_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output hlc_out_t     out_data,
  output hlc_mem_req_t mem_req,
  input  hlc_entry_t   rd_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EMIT  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic             use_mem_r, use_mem_nxt;
  hlc_out_t         res_r, res_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [31:0]      next_id_r, next_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  hlc_out_t         out_data_r, out_data_nxt;

  logic [CMP_W-1:0] count_w, cur_w, ptr_w, keep_w;
  logic             out_free, hist_last;

  assign count_w  = CMP_W'(count_r);
  assign cur_w    = CMP_W'(cur_r);
  assign ptr_w    = CMP_W'(ptr_r);
  assign keep_w   = (count_r == '0) ? '0 : cur_w + CMP_W'(1);
  assign out_free = !out_valid_r || out_ready;
  assign hist_last = (op_r == REQ_HIST) ? (ptr_w + CMP_W'(1) == count_w) : 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    use_mem_nxt   = use_mem_r;
    res_nxt       = res_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_req       = '0;

    unique case (state_r)
      // decode a new request; a read issued here lands in rd_data next cycle
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.req_type;
          use_mem_nxt = 1'b0;
          res_nxt     = '{status: ST_OK, entry_id: '0, entry_tag: '0, last: 1'b1};
          unique case (in_data.req_type) inside
            REQ_VISIT: begin
              state_nxt = S_EMIT;
              if (keep_w >= CMP_W'(HISTORY_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_req.we        = 1'b1;
                mem_req.waddr     = keep_w[IDX_W-1:0];
                mem_req.wdata     = '{id: next_id_r, tag: in_data.page_tag};
                res_nxt.entry_id  = next_id_r;
                res_nxt.entry_tag = in_data.page_tag;
                next_id_nxt       = next_id_r + 32'd1;
                count_nxt         = CNT_W'(keep_w + CMP_W'(1));
                cur_nxt           = keep_w[IDX_W-1:0];
              end
            end
            REQ_BACK: begin
              state_nxt = S_EMIT;
              if (count_r == '0 || cur_r == '0) begin
                res_nxt.status = ST_NO_PREV;
              end else begin
                cur_nxt       = cur_r - IDX_W'(1);
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_r - IDX_W'(1);
                use_mem_nxt   = 1'b1;
              end
            end
            REQ_FWD: begin
              state_nxt = S_EMIT;
              if (count_r == '0 || cur_w + CMP_W'(1) >= count_w) begin
                res_nxt.status = ST_NO_FWD;
              end else begin
                cur_nxt       = cur_r + IDX_W'(1);
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_r + IDX_W'(1);
                use_mem_nxt   = 1'b1;
              end
            end
            REQ_SHOW, REQ_CLOSE: begin
              state_nxt = S_EMIT;
              if (count_r == '0) begin
                res_nxt.status = (in_data.req_type == REQ_SHOW) ? ST_NO_TAB : ST_NO_CLOSE;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = cur_r;
                use_mem_nxt   = 1'b1;
              end
            end
            REQ_HIST: begin
              state_nxt = S_EMIT;
              if (count_r == '0) begin
                res_nxt.status = ST_NO_HIST;
              end else begin
                ptr_nxt       = '0;
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                use_mem_nxt   = 1'b1;
              end
            end
            default: begin
              // unknown request: no effect, no word out
            end
          endcase
        end
      end

      // hand one word to the output register, then decide what follows
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (use_mem_r) begin
            out_data_nxt = '{status: ST_OK, entry_id: rd_data.id,
                             entry_tag: rd_data.tag, last: hist_last};
          end else begin
            out_data_nxt = res_r;
          end
          state_nxt = S_IDLE;
          if (use_mem_r && op_r == REQ_HIST && !hist_last) begin
            // next entry of the history walk
            ptr_nxt       = ptr_r + IDX_W'(1);
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_r + IDX_W'(1);
            state_nxt     = S_EMIT;
          end else if (use_mem_r && op_r == REQ_CLOSE) begin
            if (cur_w + CMP_W'(1) < count_w) begin
              // entries follow: shift them down, cursor stays
              ptr_nxt       = cur_r;
              mem_req.re    = 1'b1;
              mem_req.raddr = cur_r + IDX_W'(1);
              state_nxt     = S_SHIFT;
            end else begin
              // closed the newest: step back, clamp at zero
              count_nxt = count_r - CNT_W'(1);
              cur_nxt   = (cur_r == '0) ? '0 : cur_r - IDX_W'(1);
            end
          end
        end
      end

      // one entry moved down per cycle, next read overlapped with this write
      S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rd_data;
        if (ptr_w + CMP_W'(2) < count_w) begin
          ptr_nxt       = ptr_r + IDX_W'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(ptr_w + CMP_W'(2));
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    use_mem_r  <= use_mem_nxt;
    res_r      <= res_nxt;
    ptr_r      <= ptr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
